FILE: rtl/isl_pkg.sv
`default_nettype none

package isl_pkg;

  localparam int BIT_COUNT    = 14;
  localparam int HEADER_SLOTS = 4;
  localparam int PERCENT_FULL = 100;

  localparam int DATA_W    = 14;
  localparam int PCT_W     = 8;
  localparam int DUTY_W    = 15;
  localparam int PCT_SAT_W = 7;
  localparam int PROD_W    = DUTY_W + PCT_SAT_W;
  localparam int REM_W     = 7;
  localparam int STEP_W    = $clog2(PROD_W);
  localparam int HEAD_W    = (HEADER_SLOTS > 1) ? $clog2(HEADER_SLOTS) : 1;
  localparam int BIT_IDX_W = (BIT_COUNT > 1) ? $clog2(BIT_COUNT) : 1;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] level;
  } isl_lvl_t;

endpackage

`default_nettype wire

FILE: rtl/isl_level.sv
`default_nettype none

module isl_level
  import isl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [DUTY_W-1:0] max_power,
  input  wire logic [PCT_W-1:0]  percent,
  output isl_lvl_t               lvl
);

  localparam logic [PCT_W-1:0]   PCT_FULL_P = PCT_W'(PERCENT_FULL);
  localparam logic [REM_W:0]     DIVISOR    = (REM_W + 1)'(PERCENT_FULL);
  localparam logic [STEP_W-1:0]  MUL_LAST   = STEP_W'(PCT_SAT_W - 1);
  localparam logic [STEP_W-1:0]  DIV_LAST   = STEP_W'(PROD_W - 1);

  logic                 run_r, run_nxt;
  logic                 div_r, div_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic [PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [PCT_SAT_W-1:0] mplier_r, mplier_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [PCT_SAT_W-1:0] pct_sat;
  logic [REM_W:0]       trial;
  logic                 qbit;

  assign pct_sat = (percent > PCT_FULL_P) ? PCT_SAT_W'(PERCENT_FULL) : percent[PCT_SAT_W-1:0];
  assign trial   = {rem_r, acc_r[PROD_W-1]};
  assign qbit    = (trial >= DIVISOR);

  always_comb begin
    run_nxt    = run_r;
    div_nxt    = div_r;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    rem_nxt    = rem_r;
    if (go) begin
      run_nxt    = 1'b1;
      div_nxt    = 1'b0;
      step_nxt   = '0;
      acc_nxt    = '0;
      mcand_nxt  = PROD_W'(max_power);
      mplier_nxt = pct_sat;
      rem_nxt    = '0;
    end else if (run_r && !div_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      step_nxt   = step_r + 1'b1;
      if (step_r == MUL_LAST) begin
        div_nxt  = 1'b1;
        step_nxt = '0;
      end
    end else if (run_r) begin
      rem_nxt  = qbit ? REM_W'(trial - DIVISOR) : trial[REM_W-1:0];
      acc_nxt  = {acc_r[PROD_W-2:0], qbit};
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      div_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      div_r  <= div_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    rem_r    <= rem_nxt;
  end

  assign lvl = '{done: done_r, level: acc_r[DUTY_W-1:0]};

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("level done held for more than one cycle");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r)
    else $error("level done while still running");

  a_div_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && div_r && !go) |-> (rem_r < REM_W'(PERCENT_FULL)))
    else $error("division remainder out of range");

endmodule

`default_nettype wire

FILE: rtl/isl_slot_seq.sv
`default_nettype none

module isl_slot_seq
  import isl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              capture,
  input  wire logic [DATA_W-1:0] data_word,
  input  wire isl_lvl_t          lvl,
  output logic                   active,
  output logic                   out_valid,
  output logic [DUTY_W-1:0]      out_duty,
  output logic                   out_last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_HEAD  = 3'd2;
  localparam logic [2:0] ST_OFF   = 3'd3;
  localparam logic [2:0] ST_ON    = 3'd4;
  localparam logic [2:0] ST_EXTRA = 3'd5;
  localparam logic [2:0] ST_TAIL  = 3'd6;

  localparam logic [HEAD_W-1:0]    HEAD_LAST = HEAD_W'(HEADER_SLOTS - 1);
  localparam logic [BIT_IDX_W-1:0] BIT_TOP   = BIT_IDX_W'(BIT_COUNT - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [HEAD_W-1:0]           head_r, head_nxt;
  logic [BIT_IDX_W-1:0]        bit_idx_r, bit_idx_nxt;
  logic [BIT_COUNT-1:0]        sh_r, sh_nxt;
  logic [DUTY_W-1:0]           level_r, level_nxt;
  logic                        valid_r, valid_nxt;
  logic [DUTY_W-1:0]           duty_r, duty_nxt;
  logic                        last_r, last_nxt;
  logic [DATA_W+BIT_COUNT-1:0] data_ext;

  assign data_ext = {{BIT_COUNT{1'b0}}, data_word};

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    bit_idx_nxt = bit_idx_r;
    sh_nxt      = sh_r;
    level_nxt   = level_r;
    valid_nxt   = 1'b0;
    duty_nxt    = duty_r;
    last_nxt    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (capture) begin
          sh_nxt    = data_ext[BIT_COUNT-1:0];
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (lvl.done) begin
          level_nxt = lvl.level;
          head_nxt  = '0;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        valid_nxt = 1'b1;
        duty_nxt  = level_r;
        head_nxt  = head_r + 1'b1;
        if (head_r == HEAD_LAST) begin
          bit_idx_nxt = BIT_TOP;
          state_nxt   = ST_OFF;
        end
      end
      ST_OFF: begin
        valid_nxt = 1'b1;
        duty_nxt  = '0;
        state_nxt = ST_ON;
      end
      ST_ON: begin
        valid_nxt = 1'b1;
        duty_nxt  = level_r;
        if (sh_r[BIT_COUNT-1]) begin
          state_nxt = ST_EXTRA;
        end else begin
          sh_nxt      = sh_r << 1;
          bit_idx_nxt = bit_idx_r - 1'b1;
          state_nxt   = (bit_idx_r == '0) ? ST_TAIL : ST_OFF;
        end
      end
      ST_EXTRA: begin
        valid_nxt   = 1'b1;
        duty_nxt    = level_r;
        sh_nxt      = sh_r << 1;
        bit_idx_nxt = bit_idx_r - 1'b1;
        state_nxt   = (bit_idx_r == '0) ? ST_TAIL : ST_OFF;
      end
      ST_TAIL: begin
        valid_nxt = 1'b1;
        duty_nxt  = '0;
        last_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r    <= head_nxt;
    bit_idx_r <= bit_idx_nxt;
    sh_r      <= sh_nxt;
    level_r   <= level_nxt;
    duty_r    <= duty_nxt;
  end

  assign active    = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign out_duty  = duty_r;
  assign out_last  = last_r;

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    last_r |-> valid_r)
    else $error("last word without strobe");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    lvl.done |-> (state_r == ST_WAIT))
    else $error("level arrived outside wait");

  a_tail_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAIL) |=> (state_r == ST_IDLE && valid_r && last_r && duty_r == '0))
    else $error("closing slot malformed");

  a_head_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HEAD) |=> (valid_r && !last_r && duty_r == level_r))
    else $error("header slot malformed");

endmodule

`default_nettype wire

FILE: rtl/ir_pulse_slot_encoder.sv
// The first slot word strobes once the level is ready after the accepting edge
// (7 multiply steps and 22 divide steps for the level, then load).
// Throughput: one slot word per cycle, 33 + (number of ones) slots per word;
// busy falls with the closing slot; no new word is taken while busy.
// Reset (synchronous, rst_n low): max_power clears to 0, sequencer goes idle.
// The receiver cannot stall: every slot word is shown for exactly one cycle.
`default_nettype none

module ir_pulse_slot_encoder
  import isl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [DUTY_W-1:0] cfg_wdata,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [DATA_W-1:0] in_data_word,
  input  wire logic [PCT_W-1:0]  in_power_percent,
  output logic                   out_valid,
  output logic [DUTY_W-1:0]      out_duty,
  output logic                   out_last
);

  logic [DUTY_W-1:0] max_power_r;
  logic              accept;
  logic              active;
  isl_lvl_t          lvl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_power_r <= '0;
    end else if (cfg_we) begin
      max_power_r <= cfg_wdata;
    end
  end

  assign accept = start && !busy;
  assign busy   = active;

  isl_level u_level (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept),
    .max_power (max_power_r),
    .percent   (in_power_percent),
    .lvl       (lvl)
  );

  isl_slot_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .capture   (accept),
    .data_word (in_data_word),
    .lvl       (lvl),
    .active    (active),
    .out_valid (out_valid),
    .out_duty  (out_duty),
    .out_last  (out_last)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  a_no_strobe_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid)
    else $error("slot word right after accept");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && $past(!busy)) |-> !out_valid)
    else $error("slot word while idle");

endmodule

`default_nettype wire
